// ===== hw/rtl/lzss_enc_pkg.sv =====
package lzss_enc_pkg;

  localparam int WINDOW_BITS = 6;
  localparam int LENGTH_BITS = 5;
  localparam int SYM_W       = 8;
  localparam int RING_SIZE   = 1 << WINDOW_BITS;
  localparam int LOOK_MAX    = (1 << LENGTH_BITS) + 1;
  localparam int HIST_LEN    = RING_SIZE - LOOK_MAX;
  localparam int CNT_W       = $clog2(LOOK_MAX + 1);
  localparam int DIST_W      = $clog2(HIST_LEN + 1);
  localparam int TOKEN_BITS  = 1 + WINDOW_BITS + LENGTH_BITS;
  localparam int LIT_BITS    = 1 + SYM_W;
  localparam int TCNT_W      = $clog2(TOKEN_BITS + 1);
  localparam int FILL_W      = $clog2(SYM_W);

  localparam logic [SYM_W-1:0] SPACE_CODE = SYM_W'(8'h20);

  typedef logic [WINDOW_BITS-1:0] ptr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [DIST_W-1:0]      dist_t;
  typedef logic [SYM_W-1:0]       sym_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ISSUE,
    ST_CHECK,
    ST_TOKEN,
    ST_SHIFT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic issue;
    logic check;
    logic load_token;
    logic shift;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic count_last;
    logic count_zero;
    logic ext;
    logic last_dist;
    logic byte_stall;
    logic tok_last;
    logic fin_stall;
    logic fill_zero;
  } status_t;

endpackage

// ===== hw/rtl/lzss_enc_sym_if.sv =====
interface lzss_enc_sym_if;
  logic                      valid;
  logic                      ready;
  logic [lzss_enc_pkg::SYM_W-1:0] symbol;
  logic                      stream_end;

  modport source(output valid, symbol, stream_end, input ready);
  modport sink(input valid, symbol, stream_end, output ready);
endinterface

// ===== hw/rtl/lzss_enc_code_if.sv =====
interface lzss_enc_code_if;
  logic                      valid;
  logic                      ready;
  logic [lzss_enc_pkg::SYM_W-1:0] code_byte;
  logic                      final_byte;

  modport source(output valid, code_byte, final_byte, input ready);
  modport sink(input valid, code_byte, final_byte, output ready);
endinterface

// ===== hw/rtl/lzss_enc_ram.sv =====
module lzss_enc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/lzss_enc_ctrl.sv =====
module lzss_enc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  input  lzss_enc_pkg::status_t  sts,
  output lzss_enc_pkg::cmd_t     cmd
);

  lzss_enc_pkg::state_t state, state_next;
  logic draining, draining_next;
  logic accept;

  assign accept = in_valid && (state == lzss_enc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lzss_enc_pkg::ST_IDLE;
      draining <= 1'b0;
    end else begin
      state    <= state_next;
      draining <= draining_next;
    end
  end

  always_comb begin
    state_next    = state;
    draining_next = draining;
    unique case (state)
      lzss_enc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_last) begin
            draining_next = 1'b1;
            state_next    = lzss_enc_pkg::ST_START;
          end else if (sts.count_last) begin
            state_next = lzss_enc_pkg::ST_START;
          end
        end
      end
      lzss_enc_pkg::ST_START: state_next = lzss_enc_pkg::ST_ISSUE;
      lzss_enc_pkg::ST_ISSUE: state_next = lzss_enc_pkg::ST_CHECK;
      lzss_enc_pkg::ST_CHECK: begin
        if (sts.ext || !sts.last_dist) begin
          state_next = lzss_enc_pkg::ST_ISSUE;
        end else begin
          state_next = lzss_enc_pkg::ST_TOKEN;
        end
      end
      lzss_enc_pkg::ST_TOKEN: state_next = lzss_enc_pkg::ST_SHIFT;
      lzss_enc_pkg::ST_SHIFT: begin
        if (!sts.byte_stall && sts.tok_last) begin
          if (!draining) begin
            state_next = lzss_enc_pkg::ST_IDLE;
          end else if (sts.count_zero) begin
            state_next = lzss_enc_pkg::ST_FIN;
          end else begin
            state_next = lzss_enc_pkg::ST_START;
          end
        end
      end
      lzss_enc_pkg::ST_FIN: begin
        if (!sts.fin_stall && sts.fill_zero) begin
          state_next    = lzss_enc_pkg::ST_IDLE;
          draining_next = 1'b0;
        end
      end
      default: state_next = lzss_enc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      lzss_enc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = accept;
      end
      lzss_enc_pkg::ST_START: cmd.start      = 1'b1;
      lzss_enc_pkg::ST_ISSUE: cmd.issue      = 1'b1;
      lzss_enc_pkg::ST_CHECK: cmd.check      = 1'b1;
      lzss_enc_pkg::ST_TOKEN: cmd.load_token = 1'b1;
      lzss_enc_pkg::ST_SHIFT: cmd.shift      = !sts.byte_stall;
      lzss_enc_pkg::ST_FIN:   cmd.fin        = !sts.fin_stall;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/lzss_enc_datapath.sv =====
module lzss_enc_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  lzss_enc_pkg::cmd_t     cmd,
  output lzss_enc_pkg::status_t  sts,
  input  lzss_enc_pkg::sym_t     in_symbol,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lzss_enc_pkg::sym_t     out_byte,
  output logic                   out_final
);

  lzss_enc_pkg::ptr_t  cp;
  lzss_enc_pkg::cnt_t  count;
  lzss_enc_pkg::dist_t hdist;
  lzss_enc_pkg::cnt_t  mlen;
  lzss_enc_pkg::cnt_t  best_len;
  lzss_enc_pkg::ptr_t  best_pos;
  lzss_enc_pkg::sym_t  first;
  logic [lzss_enc_pkg::TOKEN_BITS-1:0]  tok;
  logic [lzss_enc_pkg::TCNT_W-1:0]      tok_bits;
  lzss_enc_pkg::sym_t  acc;
  logic [lzss_enc_pkg::FILL_W-1:0]      fill;
  lzss_enc_pkg::sym_t  hold;
  logic                hold_valid;
  logic [lzss_enc_pkg::RING_SIZE-1:0]   slot_valid;
  logic                va, vb;

  lzss_enc_pkg::ptr_t  waddr, cand, addr_a, addr_b;
  lzss_enc_pkg::sym_t  qa, qb, sa, sb;
  lzss_enc_pkg::cnt_t  mlen_inc, cand_len;
  lzss_enc_pkg::sym_t  acc_set;
  logic                eq, out_free, byte_full;

  assign waddr    = cp + lzss_enc_pkg::ptr_t'(count);
  assign cand     = cp - lzss_enc_pkg::ptr_t'(hdist);
  assign addr_a   = cand + lzss_enc_pkg::ptr_t'(mlen);
  assign addr_b   = cp + lzss_enc_pkg::ptr_t'(mlen);

  lzss_enc_ram #(
    .WIDTH(lzss_enc_pkg::SYM_W),
    .DEPTH(lzss_enc_pkg::RING_SIZE)
  ) u_ring (
    .clk    (clk),
    .we     (cmd.accept),
    .waddr  (waddr),
    .wdata  (in_symbol),
    .raddr_a(addr_a),
    .rdata_a(qa),
    .raddr_b(addr_b),
    .rdata_b(qb)
  );

  // slots never written since the stream began read as spaces
  assign sa       = va ? qa : lzss_enc_pkg::SPACE_CODE;
  assign sb       = vb ? qb : lzss_enc_pkg::SPACE_CODE;
  assign eq       = (sa == sb);
  assign mlen_inc = mlen + lzss_enc_pkg::cnt_t'(1);
  assign cand_len = eq ? mlen_inc : mlen;
  assign out_free = !out_valid || out_ready;
  assign byte_full = (fill == lzss_enc_pkg::FILL_W'(lzss_enc_pkg::SYM_W - 1));

  always_comb begin
    acc_set = acc;
    acc_set[lzss_enc_pkg::FILL_W'(lzss_enc_pkg::SYM_W - 1) - fill] =
      tok[lzss_enc_pkg::TOKEN_BITS-1];
  end

  always_comb begin
    sts.count_last = (count == lzss_enc_pkg::cnt_t'(lzss_enc_pkg::LOOK_MAX - 1));
    sts.count_zero = (count == '0);
    sts.ext        = eq && (mlen_inc < count);
    sts.last_dist  = (hdist == lzss_enc_pkg::dist_t'(lzss_enc_pkg::HIST_LEN));
    sts.byte_stall = byte_full && hold_valid && !out_free;
    sts.tok_last   = (tok_bits == lzss_enc_pkg::TCNT_W'(1));
    sts.fin_stall  = hold_valid && !out_free;
    sts.fill_zero  = (fill == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cp         <= lzss_enc_pkg::ptr_t'(lzss_enc_pkg::HIST_LEN);
      count      <= '0;
      acc        <= '0;
      fill       <= '0;
      hold_valid <= 1'b0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        slot_valid[waddr] <= 1'b1;
        count             <= count + lzss_enc_pkg::cnt_t'(1);
      end
      if (cmd.load_token) begin
        if (best_len > lzss_enc_pkg::cnt_t'(1)) begin
          cp    <= cp + lzss_enc_pkg::ptr_t'(best_len);
          count <= count - best_len;
        end else begin
          cp    <= cp + lzss_enc_pkg::ptr_t'(1);
          count <= count - lzss_enc_pkg::cnt_t'(1);
        end
      end
      if (cmd.shift) begin
        if (byte_full) begin
          if (hold_valid) begin
            out_valid <= 1'b1;
          end
          hold_valid <= 1'b1;
          acc        <= '0;
        end else begin
          acc <= acc_set;
        end
        fill <= fill + lzss_enc_pkg::FILL_W'(1);
      end
      if (cmd.fin) begin
        if (fill != '0) begin
          if (hold_valid) begin
            out_valid <= 1'b1;
          end
          hold_valid <= 1'b1;
          acc        <= '0;
          fill       <= '0;
        end else begin
          out_valid  <= hold_valid;
          hold_valid <= 1'b0;
          cp         <= lzss_enc_pkg::ptr_t'(lzss_enc_pkg::HIST_LEN);
          count      <= '0;
          slot_valid <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      va <= slot_valid[addr_a];
      vb <= slot_valid[addr_b];
    end
    if (cmd.start) begin
      hdist    <= lzss_enc_pkg::dist_t'(1);
      mlen     <= '0;
      best_len <= lzss_enc_pkg::cnt_t'(1);
      best_pos <= '0;
    end
    if (cmd.check) begin
      if ((hdist == lzss_enc_pkg::dist_t'(1)) && (mlen == '0)) begin
        first <= sb;
      end
      if (sts.ext) begin
        mlen <= mlen_inc;
      end else begin
        if (cand_len > best_len) begin
          best_len <= cand_len;
          best_pos <= cand;
        end
        hdist <= hdist + lzss_enc_pkg::dist_t'(1);
        mlen  <= '0;
      end
    end
    if (cmd.load_token) begin
      if (best_len > lzss_enc_pkg::cnt_t'(1)) begin
        tok <= {1'b0, best_pos,
                lzss_enc_pkg::LENGTH_BITS'(best_len - lzss_enc_pkg::cnt_t'(2))};
        tok_bits <= lzss_enc_pkg::TCNT_W'(lzss_enc_pkg::TOKEN_BITS);
      end else begin
        tok <= {1'b1, first,
                {(lzss_enc_pkg::TOKEN_BITS - lzss_enc_pkg::LIT_BITS){1'b0}}};
        tok_bits <= lzss_enc_pkg::TCNT_W'(lzss_enc_pkg::LIT_BITS);
      end
    end
    if (cmd.shift) begin
      tok      <= tok << 1;
      tok_bits <= tok_bits - lzss_enc_pkg::TCNT_W'(1);
      if (byte_full) begin
        hold <= acc_set;
        if (hold_valid) begin
          out_byte  <= hold;
          out_final <= 1'b0;
        end
      end
    end
    if (cmd.fin) begin
      out_byte <= hold;
      if (fill != '0) begin
        hold      <= acc;
        out_final <= 1'b0;
      end else begin
        out_final <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/lzss_stream_encoder.sv =====
// lzss stream encoder
// symbols: sink channel, one 8-bit symbol per request, stream_end on the
//   last symbol of a stream. ready is high only while the block is idle.
// codes: source channel, one packed byte per request, bits msb first,
//   final_byte high on the last byte of a stream.
// a symbol that does not fill the 33-symbol lookahead is taken while the block stays idle.
// each token passes a start state, the history search (an issue and a check
//   state per symbol compared, one ring read pair per compare, over
//   31 history slots, up to the lookahead length each), a token load
//   state, then a shift state that sends its 9 or 12 bits out.
// at stream end all lookahead is coded, the partial byte is flushed with
//   zero low bits, and the block returns to its reset state.
// when the receiver stalls one finished byte waits in the output register
//   and one more in a hold register; bit shifting then pauses.
// reset clears control state and the ring slot valid bits; slots not
//   written read as spaces, so no clearing pass is needed.
module lzss_stream_encoder (
  input logic             clk,
  input logic             rst,
  lzss_enc_sym_if.sink    symbols,
  lzss_enc_code_if.source codes
);

  lzss_enc_pkg::cmd_t    cmd;
  lzss_enc_pkg::status_t sts;

  lzss_enc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(symbols.valid),
    .in_last (symbols.stream_end),
    .in_ready(symbols.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lzss_enc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_symbol(symbols.symbol),
    .out_valid(codes.valid),
    .out_ready(codes.ready),
    .out_byte (codes.code_byte),
    .out_final(codes.final_byte)
  );

`ifndef SYNTHESIS
  a_check_after_issue: assert property (@(posedge clk) disable iff (rst)
    cmd.check |-> $past(cmd.issue))
    else $error("compare without a read");

  a_no_shift_on_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> !sts.byte_stall)
    else $error("bit shifted while output blocked");

  a_token_has_lookahead: assert property (@(posedge clk) disable iff (rst)
    cmd.load_token |-> !sts.count_zero)
    else $error("token coded with empty lookahead");
`endif

endmodule
